// ===== rtl/euler_angles_to_rotation_matrix_defines.svh =====
// assertion macros for the euler angle rotation matrix block
// used by euler_angles_to_rotation_matrix.sv, no other dependencies
`ifndef EULER_ANGLES_TO_ROTATION_MATRIX_DEFINES_SVH
`define EULER_ANGLES_TO_ROTATION_MATRIX_DEFINES_SVH

// same-cycle implication under reset
`define E2RM_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("e2rm assertion failed");

// next-cycle implication under reset
`define E2RM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("e2rm assertion failed");

`endif

// ===== rtl/e2rm_pkg.sv =====
// shared constants and arithmetic helpers for the rotation matrix block
// no dependencies
package e2rm_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int OUT_FRAC_BITS_DEF = 14;
    localparam int ZW                = 36;
    localparam int CW                = 34;
    localparam int VW                = 32;

    localparam logic signed [ZW-1:0] Q30_PI      = 36'sd3373259426;
    localparam logic signed [ZW-1:0] Q30_HALF_PI = 36'sd1686629713;
    localparam logic signed [CW-1:0] CORDIC_K    = 34'sd652032874;

    // atan(2^-i) in q30
    function automatic logic signed [ZW-1:0] atan_q30(input int idx);
        logic signed [ZW-1:0] r;
        case (idx)
            0:  r = 36'sd843314856;
            1:  r = 36'sd497837829;
            2:  r = 36'sd263043836;
            3:  r = 36'sd133525158;
            4:  r = 36'sd67021686;
            5:  r = 36'sd33543515;
            6:  r = 36'sd16775850;
            7:  r = 36'sd8388437;
            8:  r = 36'sd4194282;
            9:  r = 36'sd2097149;
            10: r = 36'sd1048575;
            11: r = 36'sd524287;
            12: r = 36'sd262143;
            13: r = 36'sd131071;
            14: r = 36'sd65535;
            15: r = 36'sd32767;
            16: r = 36'sd16383;
            17: r = 36'sd8191;
            18: r = 36'sd4095;
            19: r = 36'sd2047;
            20: r = 36'sd1023;
            21: r = 36'sd511;
            22: r = 36'sd255;
            23: r = 36'sd127;
            default: r = 36'sd0;
        endcase
        return r;
    endfunction

    // q30 product, rounded with ties upward
    function automatic logic signed [VW-1:0] mul30(input logic signed [VW-1:0] a,
                                                    input logic signed [VW-1:0] b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b) + 64'sd536870912;
        return p[61:30];
    endfunction

endpackage

// ===== rtl/euler_angles_to_rotation_matrix.sv =====
// euler angle attitude to 3x3 rotation matrix, streaming pipeline
// depends on e2rm_pkg and euler_angles_to_rotation_matrix_defines.svh
//
// usage:
//   s_axis carries one word per attitude sample, m_axis one word per matrix.
//   s_axis_tdata  [15:0] angle_first, [31:16] angle_second, [47:32] angle_third,
//   signed q2.13 radians.
//   m_axis_tdata holds elem_r0c0 in [15:0] up to elem_r2c2 in [143:128],
//   row-major, signed q1.OUT_FRAC_BITS, saturated to +-1.
//   path from the accepting edge to m_axis_tvalid: the fold register, one
//   cordic iteration per stage, then sign, two multiply stages and the
//   output round stage.
//   throughput: one word per cycle while m_axis_tready does not hold the
//   pipeline; the three cordic units and the multipliers are fully pipelined.
//   reset clears all valid bits; no word is in flight afterwards.
//   when m_axis_tready is low with a word waiting, the whole pipeline
//   holds and s_axis_tready drops; nothing is lost or repeated.
//   no configuration registers.
`include "euler_angles_to_rotation_matrix_defines.svh"

module euler_angles_to_rotation_matrix #(
    parameter int CORDIC_STAGES = e2rm_pkg::CORDIC_STAGES_DEF,
    parameter int OUT_FRAC_BITS = e2rm_pkg::OUT_FRAC_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [47:0]  s_axis_tdata,   // angle_first, angle_second, angle_third
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [143:0] m_axis_tdata    // elem_r0c0 .. elem_r2c2, row-major
);

    localparam int N  = CORDIC_STAGES;
    localparam int ZW = e2rm_pkg::ZW;
    localparam int CW = e2rm_pkg::CW;
    localparam int VW = e2rm_pkg::VW;
    localparam int SH = 30 - OUT_FRAC_BITS;
    localparam logic signed [34:0] HALF = (35'sd1 <<< SH) >>> 1;
    localparam logic signed [34:0] LIM  = 35'sd1 <<< OUT_FRAC_BITS;

    logic en;
    logic vld_reg [0:N+3];

    logic signed [CW-1:0] cx_reg [0:N][0:2];
    logic signed [CW-1:0] cy_reg [0:N][0:2];
    logic signed [ZW-1:0] cz_reg [0:N][0:2];
    logic                 cf_reg [0:N][0:2];

    logic signed [VW-1:0] sn_reg [0:2];
    logic signed [VW-1:0] cs_reg [0:2];

    // pair products
    logic signed [VW-1:0] c2c3_reg, s1s2_reg, c3s1_reg, c2s3_reg, c1s2_reg, c1s3_reg;
    logic signed [VW-1:0] c1c3_reg, c3s2_reg, s1c2_reg, s2s3_reg, c1c2_reg, s1_reg;
    // s2 and s3 delayed alongside the pair products
    logic signed [VW-1:0] sn2_d_reg, sn3_d_reg;
    // triple products and delayed pairs
    logic signed [VW-1:0] t0_reg, t1_reg, t6_reg, t7_reg;
    logic signed [VW-1:0] d_c2c3_reg, d_c2s3_reg, d_c1s2_reg, d_c1s3_reg;
    logic signed [VW-1:0] d_c1c3_reg, d_c3s2_reg, d_s2s3_reg, d_c1c2_reg, d_s1_reg;

    logic [143:0] out_next;
    logic [143:0] out_reg;
    logic         out_vld_reg;

    assign en            = !out_vld_reg || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_reg;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= N + 3; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
            out_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= s_axis_tvalid;
            for (int k = 1; k <= N + 3; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
            out_vld_reg <= vld_reg[N+3];
        end
    end

    // fold angles into +-pi/2
    genvar a, g;
    generate
        for (a = 0; a < 3; a++)
        begin : g_fold
            logic signed [ZW-1:0] z_next;
            logic signed [ZW-1:0] zf_next;
            logic                 f_next;
            always_comb
            begin
                z_next = ZW'(signed'(s_axis_tdata[16*a +: 16])) <<< 17;
                if (z_next > e2rm_pkg::Q30_HALF_PI)
                begin
                    zf_next = z_next - e2rm_pkg::Q30_PI;
                    f_next  = 1'b1;
                end
                else if (z_next < -e2rm_pkg::Q30_HALF_PI)
                begin
                    zf_next = z_next + e2rm_pkg::Q30_PI;
                    f_next  = 1'b1;
                end
                else
                begin
                    zf_next = z_next;
                    f_next  = 1'b0;
                end
            end
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    cx_reg[0][a] <= e2rm_pkg::CORDIC_K;
                    cy_reg[0][a] <= '0;
                    cz_reg[0][a] <= zf_next;
                    cf_reg[0][a] <= f_next;
                end
            end

            // one cordic iteration per stage
            for (g = 0; g < N; g++)
            begin : g_iter
                logic signed [CW-1:0] x_next, y_next;
                logic signed [ZW-1:0] z_next2;
                always_comb
                begin
                    if (!cz_reg[g][a][ZW-1])
                    begin
                        x_next  = cx_reg[g][a] - (cy_reg[g][a] >>> g);
                        y_next  = cy_reg[g][a] + (cx_reg[g][a] >>> g);
                        z_next2 = cz_reg[g][a] - e2rm_pkg::atan_q30(g);
                    end
                    else
                    begin
                        x_next  = cx_reg[g][a] + (cy_reg[g][a] >>> g);
                        y_next  = cy_reg[g][a] - (cx_reg[g][a] >>> g);
                        z_next2 = cz_reg[g][a] + e2rm_pkg::atan_q30(g);
                    end
                end
                always_ff @(posedge clk)
                begin
                    if (en)
                    begin
                        cx_reg[g+1][a] <= x_next;
                        cy_reg[g+1][a] <= y_next;
                        cz_reg[g+1][a] <= z_next2;
                        cf_reg[g+1][a] <= cf_reg[g][a];
                    end
                end
            end

            // undo the fold
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    sn_reg[a] <= cf_reg[N][a] ? VW'(-cy_reg[N][a]) : VW'(cy_reg[N][a]);
                    cs_reg[a] <= cf_reg[N][a] ? VW'(-cx_reg[N][a]) : VW'(cx_reg[N][a]);
                end
            end
        end
    endgenerate

    // pair products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c2c3_reg <= e2rm_pkg::mul30(cs_reg[1], cs_reg[2]);
            s1s2_reg <= e2rm_pkg::mul30(sn_reg[0], sn_reg[1]);
            c3s1_reg <= e2rm_pkg::mul30(cs_reg[2], sn_reg[0]);
            c2s3_reg <= e2rm_pkg::mul30(cs_reg[1], sn_reg[2]);
            c1s2_reg <= e2rm_pkg::mul30(cs_reg[0], sn_reg[1]);
            c1s3_reg <= e2rm_pkg::mul30(cs_reg[0], sn_reg[2]);
            c1c3_reg <= e2rm_pkg::mul30(cs_reg[0], cs_reg[2]);
            c3s2_reg <= e2rm_pkg::mul30(cs_reg[2], sn_reg[1]);
            s1c2_reg <= e2rm_pkg::mul30(sn_reg[0], cs_reg[1]);
            s2s3_reg <= e2rm_pkg::mul30(sn_reg[1], sn_reg[2]);
            c1c2_reg <= e2rm_pkg::mul30(cs_reg[0], cs_reg[1]);
            s1_reg   <= sn_reg[0];
            sn2_d_reg <= sn_reg[1];
            sn3_d_reg <= sn_reg[2];
        end
    end

    // triple products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t0_reg     <= e2rm_pkg::mul30(s1s2_reg, sn3_d_reg);
            t1_reg     <= e2rm_pkg::mul30(c3s1_reg, sn2_d_reg);
            t6_reg     <= e2rm_pkg::mul30(s1c2_reg, sn3_d_reg);
            t7_reg     <= e2rm_pkg::mul30(c2c3_reg, s1_reg);
            d_c2c3_reg <= c2c3_reg;
            d_c2s3_reg <= c2s3_reg;
            d_c1s2_reg <= c1s2_reg;
            d_c1s3_reg <= c1s3_reg;
            d_c1c3_reg <= c1c3_reg;
            d_c3s2_reg <= c3s2_reg;
            d_s2s3_reg <= s2s3_reg;
            d_c1c2_reg <= c1c2_reg;
            d_s1_reg   <= s1_reg;
        end
    end

    function automatic logic [15:0] to_out(input logic signed [34:0] v);
        logic signed [34:0] r;
        r = (v + HALF) >>> SH;
        if (r > LIM)
        begin
            r = LIM;
        end
        if (r < -LIM)
        begin
            r = -LIM;
        end
        return r[15:0];
    endfunction

    always_comb
    begin
        out_next[15:0]    = to_out(35'(d_c2c3_reg) - 35'(t0_reg));
        out_next[31:16]   = to_out(35'(t1_reg) + 35'(d_c2s3_reg));
        out_next[47:32]   = to_out(-35'(d_c1s2_reg));
        out_next[63:48]   = to_out(-35'(d_c1s3_reg));
        out_next[79:64]   = to_out(35'(d_c1c3_reg));
        out_next[95:80]   = to_out(35'(d_s1_reg));
        out_next[111:96]  = to_out(35'(d_c3s2_reg) + 35'(t6_reg));
        out_next[127:112] = to_out(35'(d_s2s3_reg) - 35'(t7_reg));
        out_next[143:128] = to_out(35'(d_c1c2_reg));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg <= out_next;
        end
    end

    `E2RM_ASSERT_NOW(a_fold_range, clk, rst_n, vld_reg[0],
        (cz_reg[0][0] <= e2rm_pkg::Q30_HALF_PI) && (cz_reg[0][0] >= -e2rm_pkg::Q30_HALF_PI))
    `E2RM_ASSERT_NOW(a_r1c2_sat, clk, rst_n, out_vld_reg && (OUT_FRAC_BITS <= 14),
        ($signed(out_reg[95:80]) <= $signed(LIM[15:0]))
        && ($signed(out_reg[95:80]) >= -$signed(LIM[15:0])))
    `E2RM_ASSERT_NEXT(a_stall_hold, clk, rst_n, !en, $stable(vld_reg[N+3]) && $stable(out_reg))

endmodule

// ===== dv/euler_angles_to_rotation_matrix_test.sv =====
// self-checking stream test for euler_angles_to_rotation_matrix
// predicts every matrix with a bit-exact cordic and fixed-point model
// depends on the rtl block and e2rm_pkg
`timescale 1ns / 100ps

module euler_angles_to_rotation_matrix_test;

    localparam int STAGES    = e2rm_pkg::CORDIC_STAGES_DEF;
    localparam int FRAC_BITS = e2rm_pkg::OUT_FRAC_BITS_DEF;
    localparam int LATENCY   = STAGES + 5;
    localparam longint Q30_ONE_L  = 64'sd1073741824;
    localparam longint PI_L       = 64'sd3373259426;
    localparam longint HALF_PI_L  = 64'sd1686629713;
    localparam longint GAIN_L     = 64'sd652032874;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [47:0]  s_axis_tdata;   // angle_first, angle_second, angle_third
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [143:0] m_axis_tdata;   // elem_r0c0 .. elem_r2c2

    logic [47:0]  pending_angles[$];
    logic [143:0] expected_matrices[$];
    int  send_idle_pct;
    int  recv_idle_pct;
    bit  hold_send;
    int  mismatch_count;

    euler_angles_to_rotation_matrix u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    function automatic longint sra(longint v, int sh);
        return v >>> sh;
    endfunction

    function automatic void sin_cos(logic [15:0] angle, output longint s, output longint c);
        longint z;
        longint x;
        longint y;
        longint nx;
        longint atan_val;
        bit     flip;
        z = longint'($signed(angle)) * 131072;
        x = GAIN_L;
        y = 0;
        flip = 1'b0;
        if (z > HALF_PI_L)
        begin
            z = z - PI_L;
            flip = 1'b1;
        end
        else if (z < -HALF_PI_L)
        begin
            z = z + PI_L;
            flip = 1'b1;
        end
        for (int i = 0; i < STAGES && i < 24; i++)
        begin
            atan_val = longint'(e2rm_pkg::atan_q30(i));
            if (z >= 0)
            begin
                nx = x - sra(y, i);
                y  = y + sra(x, i);
                z  = z - atan_val;
            end
            else
            begin
                nx = x + sra(y, i);
                y  = y - sra(x, i);
                z  = z + atan_val;
            end
            x = nx;
        end
        s = flip ? -y : y;
        c = flip ? -x : x;
    endfunction

    function automatic longint q30_product(longint a, longint b);
        return sra(a * b + (Q30_ONE_L >>> 1), 30);
    endfunction

    function automatic logic [15:0] round_saturate(longint v);
        longint r;
        longint lim;
        lim = longint'(1) << FRAC_BITS;
        r = v;
        if (FRAC_BITS < 30)
            r = sra(v + (longint'(1) << (29 - FRAC_BITS)), 30 - FRAC_BITS);
        if (r > lim)
            r = lim;
        if (r < -lim)
            r = -lim;
        return r[15:0];
    endfunction

    function automatic logic [143:0] rotation_matrix(logic [47:0] angles);
        longint s1, c1, s2, c2, s3, c3;
        logic [143:0] m;
        sin_cos(angles[15:0], s1, c1);
        sin_cos(angles[31:16], s2, c2);
        sin_cos(angles[47:32], s3, c3);
        m[15:0]    = round_saturate(q30_product(c2, c3)
                                    - q30_product(q30_product(s1, s2), s3));
        m[31:16]   = round_saturate(q30_product(q30_product(c3, s1), s2)
                                    + q30_product(c2, s3));
        m[47:32]   = round_saturate(-q30_product(c1, s2));
        m[63:48]   = round_saturate(-q30_product(c1, s3));
        m[79:64]   = round_saturate(q30_product(c1, c3));
        m[95:80]   = round_saturate(s1);
        m[111:96]  = round_saturate(q30_product(c3, s2)
                                    + q30_product(q30_product(s1, c2), s3));
        m[127:112] = round_saturate(q30_product(s2, s3)
                                    - q30_product(q30_product(c2, c3), s1));
        m[143:128] = round_saturate(q30_product(c1, c2));
        return m;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (s_axis_tvalid)
                expected_matrices.push_back(rotation_matrix(s_axis_tdata));
            if (pending_angles.size() > 0 && !hold_send
                && $urandom_range(99) >= send_idle_pct)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= pending_angles.pop_front();
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_matrices.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected matrix word %h", m_axis_tdata);
                end
                else
                begin
                    logic [143:0] exp_m;
                    exp_m = expected_matrices.pop_front();
                    for (int k = 0; k < 9; k++)
                        if (exp_m[16*k +: 16] !== m_axis_tdata[16*k +: 16])
                        begin
                            mismatch_count++;
                            if (mismatch_count <= 10)
                                $display("element r%0dc%0d: expected %h, got %h",
                                         k / 3, k % 3, exp_m[16*k +: 16],
                                         m_axis_tdata[16*k +: 16]);
                        end
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic logic [15:0] random_angle();
        case ($urandom_range(5))
            0: return 16'h8000 + 16'($urandom_range(15));
            1: return 16'h7FFF - 16'($urandom_range(15));
            2: return 16'($signed(12868 + $urandom_range(8) - 4));   // near +pi/2
            3: return 16'($signed(-12868 - $urandom_range(8) + 4));  // near -pi/2
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic queue_angles(logic [15:0] a1, logic [15:0] a2, logic [15:0] a3);
        pending_angles.push_back({a3, a2, a1});
    endtask

    task automatic drain();
        while (pending_angles.size() > 0 || s_axis_tvalid || expected_matrices.size() > 0)
            @(posedge clk);
    endtask

    initial
    begin
        logic [15:0] edge_angles[10];
        edge_angles = '{16'h0000, 16'h7FFF, 16'h8000, 16'h0001, 16'hFFFF,
                        16'd12868, 16'd12869, -16'sd12868, -16'sd12869, 16'd25736};
        rst_n = 1'b0;
        hold_send = 1'b0;
        mismatch_count = 0;
        send_idle_pct = 35;
        recv_idle_pct = 49;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < 10; i++)
            queue_angles(edge_angles[i], edge_angles[(i + 3) % 10], edge_angles[(i + 7) % 10]);
        queue_angles(16'h5555, 16'hAAAA, 16'h0F0F);
        queue_angles(16'hAAAA, 16'h5555, 16'hF0F0);
        queue_angles(16'hFFFF, 16'hFFFF, 16'hFFFF);
        for (int i = 0; i < 190; i++)
            queue_angles(random_angle(), random_angle(), random_angle());
        drain();

        // hold the sender until the pipe is empty
        hold_send = 1'b1;
        for (int i = 0; i < 30; i++)
            queue_angles(random_angle(), random_angle(), random_angle());
        repeat (LATENCY + 5) @(posedge clk);
        hold_send = 1'b0;

        send_idle_pct = 49;
        recv_idle_pct = 35;
        for (int i = 0; i < 170; i++)
            queue_angles(random_angle(), random_angle(), random_angle());
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        for (int i = 0; i < 200; i++)
            queue_angles(random_angle(), random_angle(), random_angle());
        drain();
        repeat (LATENCY + 10) @(posedge clk);

        if (mismatch_count == 0)
            $display("euler_angles_to_rotation_matrix regression: pass");
        else
            $display("euler_angles_to_rotation_matrix regression: fail");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("euler_angles_to_rotation_matrix regression: fail");
        $finish;
    end

endmodule
